// ===== rtl/core/aup_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aup_pkg - shared types and constants for the alpha unpremultiply block
// Pixel width, lane count, divider depth and the per-lane result record.
// ----------------------------------------------------------------------------
package aup_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_LANES  = 4;
  localparam int LANE_IDX_W = 2;
  // one stage forms the numerator, then one stage per quotient bit
  localparam int Q_BITS     = PIX_W;
  localparam int LANE_STG   = Q_BITS + 1;
  localparam int REM_W      = 2 * PIX_W;

  localparam logic [PIX_W-1:0]      PIX_MAX         = 8'd255;
  localparam logic [LANE_IDX_W-1:0] ALPHA_POS_FIRST = 2'd0;
  localparam logic [LANE_IDX_W-1:0] ALPHA_POS_LAST  = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic sat;
    pix_t quo;
    pix_t alpha;
  } lane_res_t;

endpackage

// ===== rtl/core/alpha_unpremultiply.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_unpremultiply - premultiplied to straight alpha pixel converter
//
// Input channel (in_*): one 32-bit pixel per item as four bytes plus an
// end-of-frame flag. Result channel (out_*): the converted pixel, alpha byte
// unchanged, colour bytes rounded (c*255 + a/2)/a, saturated at 255, zero
// when alpha is zero. Both channels use valid/stall; an item moves on a
// rising edge with valid high and stall low.
// cfg_wr_en writes cfg_alpha_at_first_byte: 0 puts alpha in byte 3, 1 in
// byte 0. Write it only while the block is empty.
// Pipeline: an accepted item loads the numerator stage, passes through
// eight divider stages, then reaches the output register.
// Throughput: one item per cycle while out_stall is low; the four lanes
// divide in parallel and each divider stage retires one quotient bit.
// Stall: a stalled result holds in the output register; items behind it
// close up bubbles, and in_stall rises only once all ten stages are full.
// Reset: synchronous, active low; empties the pipeline and clears the
// alpha position bit to byte 3.
// ----------------------------------------------------------------------------
module alpha_unpremultiply (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_alpha_at_first_byte,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] in_pixel_byte_0,
  input  logic [7:0] in_pixel_byte_1,
  input  logic [7:0] in_pixel_byte_2,
  input  logic [7:0] in_pixel_byte_3,
  input  logic in_frame_end_in,
  output logic out_valid,
  input  logic out_stall,
  output logic [7:0] out_result_byte_0,
  output logic [7:0] out_result_byte_1,
  output logic [7:0] out_result_byte_2,
  output logic [7:0] out_result_byte_3,
  output logic out_frame_end_out
);
  import aup_pkg::*;

  logic                   cfg_alpha_first_r;
  logic [LANE_STG-1:0]    v_r;
  logic [LANE_STG-1:0]    v_nxt;
  logic [LANE_STG-1:0]    fe_r;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic [LANE_STG:0]      adv;
  pix_t [NUM_LANES-1:0]   pix_in;
  pix_t                   alpha_sel;
  lane_res_t [NUM_LANES-1:0] lane_res;
  pix_t [NUM_LANES-1:0]   result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_alpha_first_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cfg_alpha_first_r <= cfg_alpha_at_first_byte;
    end
  end

  // a stage advances when it is empty or the stage after it advances
  always_comb begin
    adv[LANE_STG] = !out_valid_r || !out_stall;
    for (int i = LANE_STG - 1; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  always_comb begin
    v_nxt = v_r;
    if (adv[0]) begin
      v_nxt[0] = in_valid;
    end
    for (int i = 1; i < LANE_STG; i++) begin
      if (adv[i]) begin
        v_nxt[i] = v_r[i-1];
      end
    end
    out_valid_nxt = adv[LANE_STG] ? v_r[LANE_STG-1] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // end-of-frame flag rides alongside the item
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      fe_r[0] <= in_frame_end_in;
    end
    for (int i = 1; i < LANE_STG; i++) begin
      if (adv[i]) begin
        fe_r[i] <= fe_r[i-1];
      end
    end
  end

  assign pix_in[0] = in_pixel_byte_0;
  assign pix_in[1] = in_pixel_byte_1;
  assign pix_in[2] = in_pixel_byte_2;
  assign pix_in[3] = in_pixel_byte_3;
  assign alpha_sel = cfg_alpha_first_r ? pix_in[ALPHA_POS_FIRST] : pix_in[ALPHA_POS_LAST];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    aup_lane u_lane (
      .clk    (clk),
      .stg_en (adv[LANE_STG-1:0]),
      .colour (pix_in[g]),
      .alpha  (alpha_sel),
      .res    (lane_res[g])
    );
  end

  aup_merge u_merge (
    .clk           (clk),
    .load          (adv[LANE_STG]),
    .alpha_first   (cfg_alpha_first_r),
    .lane_res      (lane_res),
    .frame_end     (fe_r[LANE_STG-1]),
    .result        (result),
    .frame_end_out (out_frame_end_out)
  );

  assign in_stall          = !adv[0];
  assign out_valid         = out_valid_r;
  assign out_result_byte_0 = result[0];
  assign out_result_byte_1 = result[1];
  assign out_result_byte_2 = result[2];
  assign out_result_byte_3 = result[3];

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r))
    else $error("input stalled with a free pipeline stage");

  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !v_r[LANE_STG-1]) |=> !out_valid_r)
    else $error("result repeated after it was taken");

  a_zero_alpha_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cfg_alpha_first_r && out_result_byte_3 == '0) |->
    (out_result_byte_0 == '0 && out_result_byte_1 == '0 && out_result_byte_2 == '0))
    else $error("zero alpha gave nonzero colour");

  a_zero_alpha_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg_alpha_first_r && out_result_byte_0 == '0) |->
    (out_result_byte_1 == '0 && out_result_byte_2 == '0 && out_result_byte_3 == '0))
    else $error("zero alpha gave nonzero colour");

endmodule

// ===== rtl/core/aup_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aup_lane - one colour lane
// Forms c*255 + a/2, flags quotients above 255, then runs a pipelined
// restoring divide by alpha that retires one quotient bit per stage.
// ----------------------------------------------------------------------------
module aup_lane (
  input  logic                             clk,
  input  logic [aup_pkg::LANE_STG-1:0]     stg_en,
  input  aup_pkg::pix_t                    colour,
  input  aup_pkg::pix_t                    alpha,
  output aup_pkg::lane_res_t               res
);
  import aup_pkg::*;

  logic [REM_W-1:0] rem_r   [LANE_STG];
  pix_t             alpha_r [LANE_STG];
  pix_t             quo_r   [LANE_STG];
  logic             sat_r   [LANE_STG];

  logic [REM_W-1:0] num;
  logic [REM_W-1:0] dvs_top;

  // c*255 = (c << 8) - c, plus half the divisor for round to nearest
  assign num     = ({colour, {PIX_W{1'b0}}} - REM_W'(colour)) + REM_W'(alpha >> 1);
  assign dvs_top = {alpha, {PIX_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      rem_r[0]   <= num;
      alpha_r[0] <= alpha;
      quo_r[0]   <= '0;
      sat_r[0]   <= (num >= dvs_top);
    end
  end

  for (genvar k = 1; k < LANE_STG; k++) begin : g_div
    localparam int SH = Q_BITS - k;
    logic [REM_W-1:0] dvs;
    logic             take;

    assign dvs  = REM_W'(alpha_r[k-1]) << SH;
    assign take = (rem_r[k-1] >= dvs);

    always_ff @(posedge clk) begin
      if (stg_en[k]) begin
        rem_r[k]   <= take ? (rem_r[k-1] - dvs) : rem_r[k-1];
        quo_r[k]   <= {quo_r[k-1][PIX_W-2:0], take};
        alpha_r[k] <= alpha_r[k-1];
        sat_r[k]   <= sat_r[k-1];
      end
    end
  end

  assign res.sat   = sat_r[LANE_STG-1];
  assign res.quo   = quo_r[LANE_STG-1];
  assign res.alpha = alpha_r[LANE_STG-1];

endmodule

// ===== rtl/core/aup_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aup_merge - output stage
// Puts the alpha byte back in its slot, applies zero-alpha and saturation
// rules to the colour lanes, and registers the finished pixel.
// ----------------------------------------------------------------------------
module aup_merge (
  input  logic                                          clk,
  input  logic                                          load,
  input  logic                                          alpha_first,
  input  aup_pkg::lane_res_t [aup_pkg::NUM_LANES-1:0]   lane_res,
  input  logic                                          frame_end,
  output aup_pkg::pix_t      [aup_pkg::NUM_LANES-1:0]   result,
  output logic                                          frame_end_out
);
  import aup_pkg::*;

  logic [LANE_IDX_W-1:0]  apos;
  pix_t [NUM_LANES-1:0]   result_r;
  pix_t [NUM_LANES-1:0]   result_nxt;
  logic                   frame_end_r;

  assign apos = alpha_first ? ALPHA_POS_FIRST : ALPHA_POS_LAST;

  always_comb begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (LANE_IDX_W'(k) == apos) begin
        result_nxt[k] = lane_res[k].alpha;
      end else if (lane_res[k].alpha == '0) begin
        result_nxt[k] = '0;
      end else if (lane_res[k].sat) begin
        result_nxt[k] = PIX_MAX;
      end else begin
        result_nxt[k] = lane_res[k].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r    <= result_nxt;
      frame_end_r <= frame_end;
    end
  end

  assign result        = result_r;
  assign frame_end_out = frame_end_r;

endmodule
